// ===== hdl/gdn_pkg.sv =====
`default_nettype none

package gdn_pkg;

  // Day values (absolute, shifted and intermediate) span roughly -4.2M .. +10.2M
  localparam int unsigned DW = 25;
  localparam int unsigned YW = 16;

  typedef logic signed [DW-1:0] gdn_day_t;

  // y/100 = (y * REC100) >> 21, exact for y below 43690
  localparam logic [14:0] REC100    = 15'd20972;
  localparam int unsigned REC100_SH = 21;
  // r/366 = (r * REC366) >> 32, exact for r below 2^24
  localparam logic [23:0] REC366    = 24'd11734884;
  localparam int unsigned REC366_SH = 32;

  localparam gdn_day_t E2000_ABS    = 25'sd730428;  // absolute day of 2000-01-01
  localparam gdn_day_t JAN1_OFS     = 25'sd309;     // day 1 + March-year offset 306 + 2
  localparam gdn_day_t FWD_OFS      = 25'sd2;
  localparam gdn_day_t REM_MAX      = 25'sd366;
  localparam gdn_day_t YEAR_LEN     = 25'sd365;
  localparam logic [3:0] MS_LAST    = 4'd11;

  typedef enum logic [2:0] {
    FN_DATE_TO_ABS = 3'd0,
    FN_ABS_TO_DATE = 3'd1,
    FN_DATE_TO_DOY = 3'd2,
    FN_DOY_TO_DATE = 3'd3,
    FN_DATE_TO_E2K = 3'd4,
    FN_E2K_TO_DATE = 3'd5
  } gdn_func_e;

  typedef enum logic [1:0] {
    YS_BASE = 2'd0,  // year - 1
    YS_FWD  = 2'd1,  // year, less one for January and February
    YS_LOOP = 2'd2,  // current year estimate
    YS_LEAP = 2'd3   // estimate + 1
  } gdn_ysrc_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BASE_Y1,
    ST_BASE_Y2,
    ST_BASE_SET,
    ST_FWD_Y1,
    ST_FWD_Y2,
    ST_FWD_SET,
    ST_INV_INIT,
    ST_CHK,
    ST_DIV,
    ST_ADDY,
    ST_REM_Y1,
    ST_REM_Y2,
    ST_REM_SET,
    ST_LEAP_Y1,
    ST_LEAP_SET,
    ST_MSEARCH,
    ST_MFIN,
    ST_DONE
  } gdn_state_e;

  typedef struct packed {
    logic      capture;
    gdn_ysrc_e yd_src;
    logic      yd_ld1;
    logic      yd_ld2;
    logic      base_set;
    logic      fwd_set;
    logic      inv_init;
    logic      div_ld;
    logic      addy;
    logic      rem_set;
    logic      leap_set;
    logic      k_inc;
    logic      mfin;
    logic      out_load;
  } gdn_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       rem_gt_max;
    logic       ms_hit;
    logic       k_last;
    logic       out_full;
  } gdn_stat_t;

  // Day offset of each month inside the March-based year, January first
  function automatic logic [8:0] month_offset(input logic [3:0] idx);
    logic [8:0] ofs;
    unique case (idx)
      4'd0:    ofs = 9'd306;
      4'd1:    ofs = 9'd337;
      4'd2:    ofs = 9'd0;
      4'd3:    ofs = 9'd31;
      4'd4:    ofs = 9'd61;
      4'd5:    ofs = 9'd92;
      4'd6:    ofs = 9'd122;
      4'd7:    ofs = 9'd153;
      4'd8:    ofs = 9'd184;
      4'd9:    ofs = 9'd214;
      4'd10:   ofs = 9'd245;
      4'd11:   ofs = 9'd275;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

  // Search order: Feb, Jan, Dec, Nov ... Mar (largest offset first)
  function automatic logic [3:0] search_index(input logic [3:0] k);
    logic [3:0] idx;
    unique case (k)
      4'd0:    idx = 4'd1;
      4'd1:    idx = 4'd0;
      4'd2:    idx = 4'd11;
      4'd3:    idx = 4'd10;
      4'd4:    idx = 4'd9;
      4'd5:    idx = 4'd8;
      4'd6:    idx = 4'd7;
      4'd7:    idx = 4'd6;
      4'd8:    idx = 4'd5;
      4'd9:    idx = 4'd4;
      4'd10:   idx = 4'd3;
      4'd11:   idx = 4'd2;
      default: idx = 4'd2;
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gdn_ctrl.sv =====
`default_nettype none

module gdn_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [2:0]       func_i,
  input  wire logic             out_ready_i,
  input  wire gdn_pkg::gdn_stat_t stat_i,
  output gdn_pkg::gdn_cmd_t     cmd_o
);

  gdn_pkg::gdn_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gdn_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.yd_src  = gdn_pkg::YS_LOOP;
    in_ready_o    = 1'b0;

    unique case (state_q)
      gdn_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (func_i)
            gdn_pkg::FN_DATE_TO_DOY,
            gdn_pkg::FN_DOY_TO_DATE: state_d = gdn_pkg::ST_BASE_Y1;
            gdn_pkg::FN_DATE_TO_ABS,
            gdn_pkg::FN_DATE_TO_E2K: state_d = gdn_pkg::ST_FWD_Y1;
            gdn_pkg::FN_ABS_TO_DATE,
            gdn_pkg::FN_E2K_TO_DATE: state_d = gdn_pkg::ST_INV_INIT;
            default:                 state_d = gdn_pkg::ST_DONE;
          endcase
        end
      end
      gdn_pkg::ST_BASE_Y1: begin
        cmd_o.yd_src = gdn_pkg::YS_BASE;
        cmd_o.yd_ld1 = 1'b1;
        state_d      = gdn_pkg::ST_BASE_Y2;
      end
      gdn_pkg::ST_BASE_Y2: begin
        cmd_o.yd_ld2 = 1'b1;
        state_d      = gdn_pkg::ST_BASE_SET;
      end
      gdn_pkg::ST_BASE_SET: begin
        cmd_o.base_set = 1'b1;
        if (stat_i.func == gdn_pkg::FN_DATE_TO_DOY) begin
          state_d = gdn_pkg::ST_FWD_Y1;
        end else begin
          state_d = gdn_pkg::ST_INV_INIT;
        end
      end
      gdn_pkg::ST_FWD_Y1: begin
        cmd_o.yd_src = gdn_pkg::YS_FWD;
        cmd_o.yd_ld1 = 1'b1;
        state_d      = gdn_pkg::ST_FWD_Y2;
      end
      gdn_pkg::ST_FWD_Y2: begin
        cmd_o.yd_ld2 = 1'b1;
        state_d      = gdn_pkg::ST_FWD_SET;
      end
      gdn_pkg::ST_FWD_SET: begin
        cmd_o.fwd_set = 1'b1;
        state_d       = gdn_pkg::ST_DONE;
      end
      gdn_pkg::ST_INV_INIT: begin
        cmd_o.inv_init = 1'b1;
        state_d        = gdn_pkg::ST_CHK;
      end
      gdn_pkg::ST_CHK: begin
        if (stat_i.rem_gt_max) begin
          state_d = gdn_pkg::ST_DIV;
        end else begin
          state_d = gdn_pkg::ST_LEAP_Y1;
        end
      end
      gdn_pkg::ST_DIV: begin
        cmd_o.div_ld = 1'b1;
        state_d      = gdn_pkg::ST_ADDY;
      end
      gdn_pkg::ST_ADDY: begin
        cmd_o.addy = 1'b1;
        state_d    = gdn_pkg::ST_REM_Y1;
      end
      gdn_pkg::ST_REM_Y1: begin
        cmd_o.yd_src = gdn_pkg::YS_LOOP;
        cmd_o.yd_ld1 = 1'b1;
        state_d      = gdn_pkg::ST_REM_Y2;
      end
      gdn_pkg::ST_REM_Y2: begin
        cmd_o.yd_ld2 = 1'b1;
        state_d      = gdn_pkg::ST_REM_SET;
      end
      gdn_pkg::ST_REM_SET: begin
        cmd_o.rem_set = 1'b1;
        state_d       = gdn_pkg::ST_CHK;
      end
      gdn_pkg::ST_LEAP_Y1: begin
        cmd_o.yd_src = gdn_pkg::YS_LEAP;
        cmd_o.yd_ld1 = 1'b1;
        state_d      = gdn_pkg::ST_LEAP_SET;
      end
      gdn_pkg::ST_LEAP_SET: begin
        cmd_o.leap_set = 1'b1;
        state_d        = gdn_pkg::ST_MSEARCH;
      end
      gdn_pkg::ST_MSEARCH: begin
        if (stat_i.ms_hit || stat_i.k_last) begin
          state_d = gdn_pkg::ST_MFIN;
        end else begin
          cmd_o.k_inc = 1'b1;
        end
      end
      gdn_pkg::ST_MFIN: begin
        cmd_o.mfin = 1'b1;
        state_d    = gdn_pkg::ST_DONE;
      end
      gdn_pkg::ST_DONE: begin
        if (!stat_i.out_full || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = gdn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gdn_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/gdn_datapath.sv =====
`default_nettype none

module gdn_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire gdn_pkg::gdn_cmd_t  cmd_i,
  output gdn_pkg::gdn_stat_t      stat_o,
  input  wire logic [2:0]         func_i,
  input  wire logic [13:0]        year_i,
  input  wire logic [3:0]         month_i,
  input  wire logic [4:0]         day_i,
  input  wire logic signed [22:0] day_number_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic signed [22:0]      day_count_o,
  output logic [13:0]             year_out_o,
  output logic [3:0]              month_out_o,
  output logic [4:0]              day_out_o
);

  // captured item
  logic [2:0]         func_q;
  logic [13:0]        year_q;
  logic [3:0]         midx_q;
  logic [4:0]         day_q;
  logic signed [22:0] dn_q;

  // working registers
  gdn_pkg::gdn_day_t  acc_q, a_q, rem_q, rem_d, cnt_q;
  logic [gdn_pkg::YW-1:0] y_q, y_d;
  logic [15:0]        quot_q;
  logic [3:0]         k_q;

  // year-days unit, two stages
  logic [gdn_pkg::YW-1:0] yv_q;
  logic [8:0]         q100_q;
  logic [12:0]        q4_q;
  gdn_pkg::gdn_day_t  y365_q, yd_q;

  // results
  logic [gdn_pkg::YW-1:0] res_y_q;
  logic [3:0]         res_m_q;
  logic [4:0]         res_d_q;

  // output stage
  logic               out_valid_q;
  logic signed [22:0] out_count_q;
  logic [13:0]        out_year_q;
  logic [3:0]         out_month_q;
  logic [4:0]         out_day_q;

  // month clamp
  logic [3:0] mclamp;
  always_comb begin
    if (month_i == 4'd0) begin
      mclamp = 4'd1;
    end else if (month_i > 4'd12) begin
      mclamp = 4'd12;
    end else begin
      mclamp = month_i;
    end
  end

  // year-days operand
  logic signed [gdn_pkg::YW-1:0] yin;
  always_comb begin
    unique case (cmd_i.yd_src)
      gdn_pkg::YS_BASE: yin = $signed({2'b00, year_q} - 16'd1);
      gdn_pkg::YS_FWD:  yin = $signed({2'b00, year_q} - {15'd0, (midx_q < 4'd2)});
      gdn_pkg::YS_LOOP: yin = $signed(y_q);
      gdn_pkg::YS_LEAP: yin = $signed(y_q + 16'd1);
      default:          yin = $signed(y_q);
    endcase
  end

  logic [29:0]       prod100;
  gdn_pkg::gdn_day_t yin_x, y365_c, yd_c;
  logic              yneg;
  always_comb begin
    yneg    = yin[gdn_pkg::YW-1];
    prod100 = 30'(yin[14:0]) * 30'(gdn_pkg::REC100);
    yin_x   = gdn_pkg::gdn_day_t'(yin);
    y365_c  = yin_x * gdn_pkg::YEAR_LEN;
    yd_c    = y365_q + gdn_pkg::gdn_day_t'({12'd0, q4_q})
              - gdn_pkg::gdn_day_t'({16'd0, q100_q})
              + gdn_pkg::gdn_day_t'({18'd0, q100_q[8:2]});
  end

  // reciprocal divide by 366
  logic [47:0] prod366;
  assign prod366 = 48'(rem_q[23:0]) * 48'(gdn_pkg::REC366);

  // leap test on yv_q (loaded with estimate + 1)
  logic is100, is400, notleap;
  always_comb begin
    is100   = (16'(q100_q) * 16'd100) == yv_q;
    is400   = is100 && (q100_q[1:0] == 2'b00);
    notleap = ((yv_q[1:0] != 2'b00) || is100) && !is400;
  end

  // month search
  logic [3:0] sidx;
  logic [8:0] sofs;
  gdn_pkg::gdn_day_t sofs_x, dd;
  always_comb begin
    sidx   = gdn_pkg::search_index(k_q);
    sofs   = gdn_pkg::month_offset(sidx);
    sofs_x = gdn_pkg::gdn_day_t'({16'd0, sofs});
    dd     = rem_q - sofs_x;
  end

  gdn_pkg::gdn_day_t cnt_c, a_c;
  always_comb begin
    cnt_c = yd_q + gdn_pkg::gdn_day_t'({20'd0, day_q})
            + gdn_pkg::gdn_day_t'({16'd0, gdn_pkg::month_offset(midx_q)})
            + gdn_pkg::FWD_OFS - acc_q;
    a_c   = gdn_pkg::gdn_day_t'(dn_q) + acc_q;
  end

  always_comb begin
    rem_d = rem_q;
    y_d   = y_q;
    if (cmd_i.inv_init) begin
      rem_d = a_c;
      y_d   = '0;
    end else if (cmd_i.addy) begin
      y_d = y_q + quot_q;
    end else if (cmd_i.rem_set) begin
      rem_d = a_q - yd_q - gdn_pkg::FWD_OFS;
    end else if (cmd_i.leap_set && (rem_q > gdn_pkg::YEAR_LEN) && notleap) begin
      rem_d = rem_q - gdn_pkg::YEAR_LEN;
      y_d   = y_q + 16'd1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      year_q <= year_i;
      midx_q <= mclamp - 4'd1;
      day_q  <= day_i;
      dn_q   <= day_number_i;
      if ((func_i == gdn_pkg::FN_DATE_TO_E2K) || (func_i == gdn_pkg::FN_E2K_TO_DATE)) begin
        acc_q <= gdn_pkg::E2000_ABS;
      end else begin
        acc_q <= '0;
      end
    end else if (cmd_i.base_set) begin
      acc_q <= yd_q + gdn_pkg::JAN1_OFS;
    end
    if (cmd_i.yd_ld1) begin
      yv_q   <= $unsigned(yin);
      y365_q <= y365_c;
      q100_q <= yneg ? 9'd0 : prod100[gdn_pkg::REC100_SH +: 9];
      q4_q   <= yneg ? 13'd0 : yin[14:2];
    end
    if (cmd_i.yd_ld2) begin
      yd_q <= yd_c;
    end
    if (cmd_i.fwd_set) begin
      cnt_q <= cnt_c;
    end
    if (cmd_i.inv_init) begin
      a_q <= a_c;
    end
    if (cmd_i.div_ld) begin
      quot_q <= prod366[gdn_pkg::REC366_SH +: 16];
    end
    rem_q <= rem_d;
    y_q   <= y_d;
    if (cmd_i.leap_set) begin
      k_q <= '0;
    end else if (cmd_i.k_inc) begin
      k_q <= k_q + 4'd1;
    end
    if (cmd_i.mfin) begin
      res_y_q <= y_q + {15'd0, (sidx < 4'd2)};
      res_m_q <= sidx + 4'd1;
      res_d_q <= dd[4:0];
    end
  end

  // output stage
  logic is_fwd, is_inv;
  always_comb begin
    is_fwd = (func_q == gdn_pkg::FN_DATE_TO_ABS) || (func_q == gdn_pkg::FN_DATE_TO_DOY)
             || (func_q == gdn_pkg::FN_DATE_TO_E2K);
    is_inv = (func_q == gdn_pkg::FN_ABS_TO_DATE) || (func_q == gdn_pkg::FN_DOY_TO_DATE)
             || (func_q == gdn_pkg::FN_E2K_TO_DATE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_count_q <= is_fwd ? cnt_q[22:0] : '0;
      out_year_q  <= is_inv ? res_y_q[13:0] : '0;
      out_month_q <= is_inv ? res_m_q : '0;
      out_day_q   <= is_inv ? res_d_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign day_count_o = out_count_q;
  assign year_out_o  = out_year_q;
  assign month_out_o = out_month_q;
  assign day_out_o   = out_day_q;

  always_comb begin
    stat_o.func       = func_q;
    stat_o.rem_gt_max = rem_q > gdn_pkg::REM_MAX;
    stat_o.ms_hit     = rem_q > sofs_x;
    stat_o.k_last     = k_q == gdn_pkg::MS_LAST;
    stat_o.out_full   = out_valid_q;
  end

endmodule

`default_nettype wire

// ===== hdl/gregorian_day_number_converter.sv =====
`default_nettype none

// Channel  Dir  Handshake               Payload
// in       in   in_valid_i / in_ready_o func_i, year_i, month_i, day_i, day_number_i
// out      out  out_valid_o/out_ready_i day_count_o, year_out_o, month_out_o, day_out_o
//
// One item at a time. Date-to-number ops step FWD_Y1, FWD_Y2, FWD_SET and DONE;
// day of year steps BASE_Y1, BASE_Y2 and BASE_SET first, as it runs the two-stage
// year-days unit twice. Number-to-date ops step INV_INIT, then year-estimate
// passes (usually 2 or 3) from CHK to REM_SET, then LEAP_Y1, LEAP_SET, a month
// search, MFIN and DONE; day of year runs the BASE states first.
// Reset clears only the sequencer and output valid. An untaken result stalls the
// next item only in its last cycle, where it waits for the output register.

module gregorian_day_number_converter (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         func_i,
  input  wire logic [13:0]        year_i,
  input  wire logic [3:0]         month_i,
  input  wire logic [4:0]         day_i,
  input  wire logic signed [22:0] day_number_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [22:0]      day_count_o,
  output logic [13:0]             year_out_o,
  output logic [3:0]              month_out_o,
  output logic [4:0]              day_out_o
);

  gdn_pkg::gdn_cmd_t  cmd;
  gdn_pkg::gdn_stat_t stat;

  // sequencer: op dispatch, year refinement loop, month search
  gdn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // year-days unit, /366 reciprocal, month table and output register
  gdn_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .func_i       (func_i),
    .year_i       (year_i),
    .month_i      (month_i),
    .day_i        (day_i),
    .day_number_i (day_number_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .day_count_o  (day_count_o),
    .year_out_o   (year_out_o),
    .month_out_o  (month_out_o),
    .day_out_o    (day_out_o)
  );

endmodule

`default_nettype wire
